>>> design/ltri_pkg.sv
// Shared types, constants and the micro-op program of the trilateration solver.
// Used by ltri_mac, ltri_div and least_squares_trilateration_2d; no dependencies.
`timescale 1ns / 1ps

package ltri_pkg;

  // Widths of the data path.
  localparam int unsigned WORD_W   = 128;
  localparam int unsigned MPLR_W   = 64;
  localparam int unsigned NBITS_W  = 6;
  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned RF_DEPTH = 27;
  localparam int unsigned POS_W    = 24;
  localparam int unsigned COORD_W  = 16;
  localparam int unsigned DIST_W   = 16;
  localparam int unsigned NUM_REGS = 6;
  localparam int unsigned NUM_ANCHORS = 3;

  // Input actions.
  localparam logic ACT_STORE    = 1'b0;
  localparam logic ACT_ESTIMATE = 1'b1;

  // Register file addresses.
  localparam logic [ADDR_W-1:0] R_X0  = 5'd0;
  localparam logic [ADDR_W-1:0] R_Y0  = 5'd1;
  localparam logic [ADDR_W-1:0] R_X1  = 5'd2;
  localparam logic [ADDR_W-1:0] R_Y1  = 5'd3;
  localparam logic [ADDR_W-1:0] R_X2  = 5'd4;
  localparam logic [ADDR_W-1:0] R_Y2  = 5'd5;
  localparam logic [ADDR_W-1:0] R_D0  = 5'd6;
  localparam logic [ADDR_W-1:0] R_D1  = 5'd7;
  localparam logic [ADDR_W-1:0] R_D2  = 5'd8;
  localparam logic [ADDR_W-1:0] R_TWO = 5'd9;
  localparam logic [ADDR_W-1:0] R_A0  = 5'd10;
  localparam logic [ADDR_W-1:0] R_A1  = 5'd11;
  localparam logic [ADDR_W-1:0] R_A2  = 5'd12;
  localparam logic [ADDR_W-1:0] R_B0  = 5'd13;
  localparam logic [ADDR_W-1:0] R_B1  = 5'd14;
  localparam logic [ADDR_W-1:0] R_B2  = 5'd15;
  localparam logic [ADDR_W-1:0] R_C0  = 5'd16;
  localparam logic [ADDR_W-1:0] R_C1  = 5'd17;
  localparam logic [ADDR_W-1:0] R_C2  = 5'd18;
  localparam logic [ADDR_W-1:0] R_M00 = 5'd19;
  localparam logic [ADDR_W-1:0] R_M01 = 5'd20;
  localparam logic [ADDR_W-1:0] R_M11 = 5'd21;
  localparam logic [ADDR_W-1:0] R_V0  = 5'd22;
  localparam logic [ADDR_W-1:0] R_V1  = 5'd23;
  localparam logic [ADDR_W-1:0] R_DET = 5'd24;
  localparam logic [ADDR_W-1:0] R_NX  = 5'd25;
  localparam logic [ADDR_W-1:0] R_NY  = 5'd26;
  localparam logic [ADDR_W-1:0] LOAD_LAST = R_TWO;

  localparam int unsigned OP_W     = 6;
  localparam logic [OP_W-1:0] OP_LAST = 6'd50;

  // One micro-op: dst = (clr ? 0 : dst) +/- x * y, over nbits multiplier bits.
  typedef struct packed {
    logic [ADDR_W-1:0]  dst;
    logic [ADDR_W-1:0]  xa;
    logic [ADDR_W-1:0]  ya;
    logic               clr;
    logic               sub;
    logic [NBITS_W-1:0] nbits;
  } ltri_op_t;

  // Command handed to the multiply-accumulate unit.
  typedef struct packed {
    logic [WORD_W-1:0]  x;
    logic [WORD_W-1:0]  y;
    logic [NBITS_W-1:0] nbits;
    logic               clr;
    logic               sub;
  } ltri_mac_cmd_t;

  function automatic ltri_op_t mk(input logic [ADDR_W-1:0] dst, input logic [ADDR_W-1:0] xa,
                                  input logic [ADDR_W-1:0] ya, input logic clr,
                                  input logic sub, input logic [NBITS_W-1:0] nbits);
    ltri_op_t o;
    o.dst = dst; o.xa = xa; o.ya = ya; o.clr = clr; o.sub = sub; o.nbits = nbits;
    return o;
  endfunction

  // Program: pair terms, right-hand sides, normal equations, determinant, numerators.
  function automatic ltri_op_t op_rom(input logic [OP_W-1:0] idx);
    ltri_op_t o;
    o = mk(R_NY, R_V0, R_M01, 1'b0, 1'b1, 6'd40);
    case (idx)
      6'd0:  o = mk(R_A0, R_X1, R_TWO, 1'b1, 1'b0, 6'd2);
      6'd1:  o = mk(R_A0, R_X0, R_TWO, 1'b0, 1'b1, 6'd2);
      6'd2:  o = mk(R_A1, R_X2, R_TWO, 1'b1, 1'b0, 6'd2);
      6'd3:  o = mk(R_A1, R_X0, R_TWO, 1'b0, 1'b1, 6'd2);
      6'd4:  o = mk(R_A2, R_X2, R_TWO, 1'b1, 1'b0, 6'd2);
      6'd5:  o = mk(R_A2, R_X1, R_TWO, 1'b0, 1'b1, 6'd2);
      6'd6:  o = mk(R_B0, R_Y1, R_TWO, 1'b1, 1'b0, 6'd2);
      6'd7:  o = mk(R_B0, R_Y0, R_TWO, 1'b0, 1'b1, 6'd2);
      6'd8:  o = mk(R_B1, R_Y2, R_TWO, 1'b1, 1'b0, 6'd2);
      6'd9:  o = mk(R_B1, R_Y0, R_TWO, 1'b0, 1'b1, 6'd2);
      6'd10: o = mk(R_B2, R_Y2, R_TWO, 1'b1, 1'b0, 6'd2);
      6'd11: o = mk(R_B2, R_Y1, R_TWO, 1'b0, 1'b1, 6'd2);
      6'd12: o = mk(R_C0, R_D0, R_D0, 1'b1, 1'b0, 6'd16);
      6'd13: o = mk(R_C0, R_D1, R_D1, 1'b0, 1'b1, 6'd16);
      6'd14: o = mk(R_C0, R_X1, R_X1, 1'b0, 1'b0, 6'd16);
      6'd15: o = mk(R_C0, R_X0, R_X0, 1'b0, 1'b1, 6'd16);
      6'd16: o = mk(R_C0, R_Y1, R_Y1, 1'b0, 1'b0, 6'd16);
      6'd17: o = mk(R_C0, R_Y0, R_Y0, 1'b0, 1'b1, 6'd16);
      6'd18: o = mk(R_C1, R_D0, R_D0, 1'b1, 1'b0, 6'd16);
      6'd19: o = mk(R_C1, R_D2, R_D2, 1'b0, 1'b1, 6'd16);
      6'd20: o = mk(R_C1, R_X2, R_X2, 1'b0, 1'b0, 6'd16);
      6'd21: o = mk(R_C1, R_X0, R_X0, 1'b0, 1'b1, 6'd16);
      6'd22: o = mk(R_C1, R_Y2, R_Y2, 1'b0, 1'b0, 6'd16);
      6'd23: o = mk(R_C1, R_Y0, R_Y0, 1'b0, 1'b1, 6'd16);
      6'd24: o = mk(R_C2, R_D1, R_D1, 1'b1, 1'b0, 6'd16);
      6'd25: o = mk(R_C2, R_D2, R_D2, 1'b0, 1'b1, 6'd16);
      6'd26: o = mk(R_C2, R_X2, R_X2, 1'b0, 1'b0, 6'd16);
      6'd27: o = mk(R_C2, R_X1, R_X1, 1'b0, 1'b1, 6'd16);
      6'd28: o = mk(R_C2, R_Y2, R_Y2, 1'b0, 1'b0, 6'd16);
      6'd29: o = mk(R_C2, R_Y1, R_Y1, 1'b0, 1'b1, 6'd16);
      6'd30: o = mk(R_M00, R_A0, R_A0, 1'b1, 1'b0, 6'd18);
      6'd31: o = mk(R_M00, R_A1, R_A1, 1'b0, 1'b0, 6'd18);
      6'd32: o = mk(R_M00, R_A2, R_A2, 1'b0, 1'b0, 6'd18);
      6'd33: o = mk(R_M01, R_B0, R_A0, 1'b1, 1'b0, 6'd18);
      6'd34: o = mk(R_M01, R_B1, R_A1, 1'b0, 1'b0, 6'd18);
      6'd35: o = mk(R_M01, R_B2, R_A2, 1'b0, 1'b0, 6'd18);
      6'd36: o = mk(R_M11, R_B0, R_B0, 1'b1, 1'b0, 6'd18);
      6'd37: o = mk(R_M11, R_B1, R_B1, 1'b0, 1'b0, 6'd18);
      6'd38: o = mk(R_M11, R_B2, R_B2, 1'b0, 1'b0, 6'd18);
      6'd39: o = mk(R_V0, R_C0, R_A0, 1'b1, 1'b0, 6'd18);
      6'd40: o = mk(R_V0, R_C1, R_A1, 1'b0, 1'b0, 6'd18);
      6'd41: o = mk(R_V0, R_C2, R_A2, 1'b0, 1'b0, 6'd18);
      6'd42: o = mk(R_V1, R_C0, R_B0, 1'b1, 1'b0, 6'd18);
      6'd43: o = mk(R_V1, R_C1, R_B1, 1'b0, 1'b0, 6'd18);
      6'd44: o = mk(R_V1, R_C2, R_B2, 1'b0, 1'b0, 6'd18);
      6'd45: o = mk(R_DET, R_M00, R_M11, 1'b1, 1'b0, 6'd40);
      6'd46: o = mk(R_DET, R_M01, R_M01, 1'b0, 1'b1, 6'd40);
      6'd47: o = mk(R_NX, R_V0, R_M11, 1'b1, 1'b0, 6'd40);
      6'd48: o = mk(R_NX, R_V1, R_M01, 1'b0, 1'b1, 6'd40);
      6'd49: o = mk(R_NY, R_V1, R_M00, 1'b1, 1'b0, 6'd40);
      default: o = mk(R_NY, R_V0, R_M01, 1'b0, 1'b1, 6'd40);
    endcase
    return o;
  endfunction

endpackage

>>> design/ltri_mac.sv
// Shift-and-add multiply-accumulate unit shared by every product of the solver.
// Depends on ltri_pkg for widths and the command struct.
`timescale 1ns / 1ps

module ltri_mac (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  ltri_pkg::ltri_mac_cmd_t        cmd_i,
  output logic                           done_o,
  output logic [ltri_pkg::WORD_W-1:0]    result_o
);
  import ltri_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [NBITS_W-1:0] cnt_q, cnt_d;
  logic [WORD_W-1:0]  mcand_q, mcand_d;
  logic [MPLR_W-1:0]  mplr_q, mplr_d;
  logic [WORD_W-1:0]  prod_q, prod_d;
  logic [WORD_W-1:0]  acc_q, acc_d;
  logic               neg_q, neg_d;
  logic               clr_q, clr_d;
  logic [WORD_W-1:0]  y_mag;
  logic [WORD_W-1:0]  acc_base;

  // Magnitude of the multiplier; its sign folds into the final add or subtract.
  assign y_mag    = cmd_i.y[WORD_W-1] ? (~cmd_i.y + 1'b1) : cmd_i.y;
  assign acc_base = clr_q ? '0 : acc_q;

  // Sequencer of one product: one multiplier bit per cycle.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    mcand_d = mcand_q;
    mplr_d  = mplr_q;
    prod_d  = prod_q;
    acc_d   = acc_q;
    neg_d   = neg_q;
    clr_d   = clr_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          mcand_d = cmd_i.x;
          mplr_d  = y_mag[MPLR_W-1:0];
          cnt_d   = cmd_i.nbits;
          prod_d  = '0;
          neg_d   = cmd_i.y[WORD_W-1] ^ cmd_i.sub;
          clr_d   = cmd_i.clr;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (mplr_q[0]) begin
          prod_d = prod_q + mcand_q;
        end
        mcand_d = {mcand_q[WORD_W-2:0], 1'b0};
        mplr_d  = {1'b0, mplr_q[MPLR_W-1:1]};
        cnt_d   = cnt_q - 1'b1;
        if (cnt_q == NBITS_W'(1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        acc_d   = neg_q ? (acc_base - prod_q) : (acc_base + prod_q);
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign done_o   = (state_q == ST_FIN);
  assign result_o = acc_d;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Data path registers.
  always_ff @(posedge clk_i) begin
    mcand_q <= mcand_d;
    mplr_q  <= mplr_d;
    prod_q  <= prod_d;
    acc_q   <= acc_d;
    neg_q   <= neg_d;
    clr_q   <= clr_d;
  end

endmodule

>>> design/ltri_div.sv
// Restoring divider, one quotient bit per cycle, with truncation toward zero
// and saturation to the 24-bit position range. Depends on ltri_pkg.
`timescale 1ns / 1ps

module ltri_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ltri_pkg::WORD_W-1:0]   num_i,
  input  logic [ltri_pkg::WORD_W-1:0]   den_i,
  output logic                          done_o,
  output logic [ltri_pkg::POS_W-1:0]    quot_o
);
  import ltri_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;
  localparam int unsigned CNT_W  = $clog2(WORD_W);
  localparam logic [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic [POS_W-1:0] POS_MIN_MAG = {1'b1, {(POS_W-1){1'b0}}};

  logic [1:0]        state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [WORD_W-1:0] nmag_q, nmag_d;
  logic [WORD_W-1:0] dmag_q, dmag_d;
  logic [WORD_W-1:0] rem_q, rem_d;
  logic [WORD_W-1:0] quot_q, quot_d;
  logic              neg_q, neg_d;
  logic [WORD_W-1:0] rem_sh;
  logic              fits;
  logic              hi_any;
  logic [POS_W-1:0]  mag;

  assign rem_sh = {rem_q[WORD_W-2:0], nmag_q[WORD_W-1]};
  assign fits   = (rem_sh >= dmag_q);

  // One quotient bit per cycle, most significant first.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    nmag_d  = nmag_q;
    dmag_d  = dmag_q;
    rem_d   = rem_q;
    quot_d  = quot_q;
    neg_d   = neg_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          nmag_d  = num_i[WORD_W-1] ? (~num_i + 1'b1) : num_i;
          dmag_d  = den_i[WORD_W-1] ? (~den_i + 1'b1) : den_i;
          neg_d   = num_i[WORD_W-1] ^ den_i[WORD_W-1];
          rem_d   = '0;
          quot_d  = '0;
          cnt_d   = '1;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        rem_d  = fits ? (rem_sh - dmag_q) : rem_sh;
        quot_d = {quot_q[WORD_W-2:0], fits};
        nmag_d = {nmag_q[WORD_W-2:0], 1'b0};
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Saturate the magnitude, then apply the sign.
  assign hi_any = |quot_q[WORD_W-1:POS_W];
  always_comb begin
    if (neg_q) begin
      mag    = (hi_any || (quot_q[POS_W-1:0] > POS_MIN_MAG)) ? POS_MIN_MAG
                                                              : quot_q[POS_W-1:0];
      quot_o = ~mag + 1'b1;
    end else begin
      mag    = (hi_any || quot_q[POS_W-1]) ? POS_MAX : quot_q[POS_W-1:0];
      quot_o = mag;
    end
  end

  assign done_o = (state_q == ST_FIN);

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Data path registers.
  always_ff @(posedge clk_i) begin
    nmag_q <= nmag_d;
    dmag_q <= dmag_d;
    rem_q  <= rem_d;
    quot_q <= quot_d;
    neg_q  <= neg_d;
  end

endmodule

>>> design/least_squares_trilateration_2d.sv
// Top level of the three-anchor 2D least-squares position solver: sequencer,
// operand register file, anchor and distance storage. Uses ltri_pkg, ltri_mac, ltri_div.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid_i/in_ready_o  action_i, anchor_index_i, distance_cm_i
//   out      source     out_valid_o/out_ready_i pos_x_o, pos_y_o, valid_res_o, dist_a*_o
//   cfg      sink       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// An estimate loads the ten input registers of the register file, runs 51
// multiply-accumulate steps on the shared shift-and-add unit and, unless the
// determinant is zero, two runs of the serial divider, x then y.
// Input ready is low while an estimate is in progress; a finished result waits in
// the output register, and the next estimate holds its result until that is taken.
// Reset clears anchors, distances and control state; no clearing pass is needed.
`timescale 1ns / 1ps

module least_squares_trilateration_2d (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           action_i,
  input  logic [1:0]                     anchor_index_i,
  input  logic [ltri_pkg::DIST_W-1:0]    distance_cm_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [ltri_pkg::POS_W-1:0] pos_x_o,
  output logic signed [ltri_pkg::POS_W-1:0] pos_y_o,
  output logic                           valid_res_o,
  output logic [ltri_pkg::DIST_W-1:0]    dist_a0_o,
  output logic [ltri_pkg::DIST_W-1:0]    dist_a1_o,
  output logic [ltri_pkg::DIST_W-1:0]    dist_a2_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [2:0]                     cfg_index_i,
  input  logic [ltri_pkg::COORD_W-1:0]   cfg_data_i
);
  import ltri_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOAD  = 3'd1;
  localparam logic [2:0] ST_ISSUE = 3'd2;
  localparam logic [2:0] ST_OPRD  = 3'd3;
  localparam logic [2:0] ST_MAC   = 3'd4;
  localparam logic [2:0] ST_DIVX  = 3'd5;
  localparam logic [2:0] ST_DIVY  = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  logic [2:0]          state_q, state_d;
  logic [ADDR_W-1:0]   ld_q, ld_d;
  logic [OP_W-1:0]     op_idx_q, op_idx_d;
  logic                div_act_q, div_act_d;
  logic [COORD_W-1:0]  cfg_q [NUM_REGS];
  logic [DIST_W-1:0]   dist_q [NUM_ANCHORS];
  logic [WORD_W-1:0]   rf [RF_DEPTH];
  logic [WORD_W-1:0]   rdx_q, rdy_q;
  logic [WORD_W-1:0]   det_q, nx_q, ny_q;
  logic                out_valid_q;
  logic [POS_W-1:0]    pos_x_q, pos_y_q;
  logic                valid_res_q;
  logic [DIST_W-1:0]   out_d0_q, out_d1_q, out_d2_q;
  ltri_op_t            op;
  ltri_mac_cmd_t       mac_cmd;
  logic                mac_start, mac_done;
  logic [WORD_W-1:0]   mac_result;
  logic                div_start, div_done;
  logic [POS_W-1:0]    div_quot;
  logic                rf_we;
  logic [ADDR_W-1:0]   rf_waddr;
  logic [WORD_W-1:0]   rf_wdata;
  logic [WORD_W-1:0]   ld_data;
  logic                in_xfer, est_xfer, out_xfer;

  assign op          = op_rom(op_idx_q);
  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_xfer     = in_valid_i && in_ready_o;
  assign est_xfer    = in_xfer && (action_i == ACT_ESTIMATE);
  assign out_xfer    = out_valid_q && out_ready_i;

  // Anchor coordinate registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) cfg_q[i] <= '0;
    end else if (cfg_valid_i && (cfg_index_i < 3'(NUM_REGS))) begin
      cfg_q[cfg_index_i] <= cfg_data_i;
    end
  end

  // Latest distance per anchor; an out-of-range anchor index is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_ANCHORS; i++) dist_q[i] <= '0;
    end else if (in_xfer && (action_i == ACT_STORE) &&
                 (anchor_index_i < 2'(NUM_ANCHORS))) begin
      dist_q[anchor_index_i] <= distance_cm_i;
    end
  end

  // Values loaded into the register file before the program runs.
  always_comb begin
    ld_data = WORD_W'(2);
    case (ld_q) inside
      R_X0, R_Y0, R_X1, R_Y1, R_X2, R_Y2: begin
        ld_data = {{(WORD_W-COORD_W){cfg_q[ld_q[2:0]][COORD_W-1]}}, cfg_q[ld_q[2:0]]};
      end
      R_D0: ld_data = {{(WORD_W-DIST_W){1'b0}}, dist_q[0]};
      R_D1: ld_data = {{(WORD_W-DIST_W){1'b0}}, dist_q[1]};
      R_D2: ld_data = {{(WORD_W-DIST_W){1'b0}}, dist_q[2]};
      default: ld_data = WORD_W'(2);
    endcase
  end

  assign rf_we    = (state_q == ST_LOAD) || ((state_q == ST_MAC) && mac_done);
  assign rf_waddr = (state_q == ST_LOAD) ? ld_q : op.dst;
  assign rf_wdata = (state_q == ST_LOAD) ? ld_data : mac_result;

  // Operand register file: one write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf[rf_waddr] <= rf_wdata;
    end
    rdx_q <= rf[op.xa];
    rdy_q <= rf[op.ya];
  end

  // Keep the determinant and numerators for the divider.
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_MAC) && mac_done) begin
      if (op.dst == R_DET) det_q <= mac_result;
      if (op.dst == R_NX)  nx_q  <= mac_result;
      if (op.dst == R_NY)  ny_q  <= mac_result;
    end
  end

  assign mac_start     = (state_q == ST_OPRD);
  assign mac_cmd.x     = rdx_q;
  assign mac_cmd.y     = rdy_q;
  assign mac_cmd.nbits = op.nbits;
  assign mac_cmd.clr   = op.clr;
  assign mac_cmd.sub   = op.sub;

  ltri_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mac_start),
    .cmd_i    (mac_cmd),
    .done_o   (mac_done),
    .result_o (mac_result)
  );

  assign div_start = ((state_q == ST_DIVX) || (state_q == ST_DIVY)) && !div_act_q;

  ltri_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ((state_q == ST_DIVY) ? ny_q : nx_q),
    .den_i   (det_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    ld_d      = ld_q;
    op_idx_d  = op_idx_q;
    div_act_d = div_act_q;
    unique case (state_q) inside
      ST_IDLE: begin
        if (est_xfer) begin
          ld_d    = '0;
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        ld_d = ld_q + 1'b1;
        if (ld_q == LOAD_LAST) begin
          op_idx_d = '0;
          state_d  = ST_ISSUE;
        end
      end
      ST_ISSUE: state_d = ST_OPRD;
      ST_OPRD:  state_d = ST_MAC;
      ST_MAC: begin
        if (mac_done) begin
          if (op_idx_q == OP_LAST) begin
            state_d = (det_q == '0) ? ST_DONE : ST_DIVX;
          end else begin
            op_idx_d = op_idx_q + 1'b1;
            state_d  = ST_ISSUE;
          end
        end
      end
      ST_DIVX, ST_DIVY: begin
        if (div_start) begin
          div_act_d = 1'b1;
        end
        if (div_done) begin
          div_act_d = 1'b0;
          state_d   = (state_q == ST_DIVX) ? ST_DIVY : ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      ld_q      <= '0;
      op_idx_q  <= '0;
      div_act_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ld_q      <= ld_d;
      op_idx_q  <= op_idx_d;
      div_act_q <= div_act_d;
    end
  end

  // Working position; cleared for a singular system.
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_MAC) && mac_done && (op_idx_q == OP_LAST)) begin
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      valid_res_q <= (det_q != '0);
    end else if ((state_q == ST_DIVX) && div_done) begin
      pos_x_q <= div_quot;
    end else if ((state_q == ST_DIVY) && div_done) begin
      pos_y_q <= div_quot;
    end
  end

  // Output register: filled once the previous result has been transferred.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_DONE) && !out_valid_q) begin
      out_valid_q <= 1'b1;
    end else if (out_xfer) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_DONE) && !out_valid_q) begin
      pos_x_o     <= pos_x_q;
      pos_y_o     <= pos_y_q;
      valid_res_o <= valid_res_q;
      out_d0_q    <= dist_q[0];
      out_d1_q    <= dist_q[1];
      out_d2_q    <= dist_q[2];
    end
  end

  assign out_valid_o = out_valid_q;
  assign dist_a0_o   = out_d0_q;
  assign dist_a1_o   = out_d1_q;
  assign dist_a2_o   = out_d2_q;

  // A singular system reports the origin.
  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !valid_res_o) |-> (pos_x_o == '0 && pos_y_o == '0))
    else $error("singular result carries a nonzero position");

  // The multiply unit finishes only while the sequencer waits for it.
  a_mac_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_done |-> (state_q == ST_MAC))
    else $error("multiply unit finished outside its wait state");

  // An accepted estimate starts the register file load.
  a_est_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    est_xfer |=> (state_q == ST_LOAD && ld_q == '0))
    else $error("estimate did not start the load");

  // The program counter never runs past the last micro-op.
  a_op_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_idx_q <= OP_LAST)
    else $error("micro-op index out of range");

endmodule
